[sv/hsl_to_rgb_converter_top_defines.svh]
// Assertion macros shared by the colour conversion RTL.
// Define NO_ASSERTIONS to build without them.
`ifndef HSL_TO_RGB_CONVERTER_TOP_DEFINES_SVH
`define HSL_TO_RGB_CONVERTER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, checked outside reset
`define HSL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hsl_to_rgb: check failed");
// Next-cycle implication, checked outside reset
`define HSL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hsl_to_rgb: check failed");
`else
`define HSL_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define HSL_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[sv/hsl2rgb_pkg.sv]
package hsl2rgb_pkg;

    // Output level width
    localparam int LEVEL_BITS = 16;
    localparam int NUM_CH     = 3;

    // Input field widths
    localparam int HUE_W = 13;
    localparam int PCT_W = 11;

    // Stream widths, padded to whole bytes
    localparam int IN_W     = HUE_W + 2 * PCT_W;
    localparam int IN_TDW   = ((IN_W + 7) / 8) * 8;
    localparam int OUT_W    = NUM_CH * LEVEL_BITS;
    localparam int OUT_TDW  = ((OUT_W + 7) / 8) * 8;

    // Hue positions in 1/5760 of a turn
    localparam logic [HUE_W-1:0] FULL_TURN       = 13'd5760;
    localparam logic [HUE_W-1:0] THIRD_TURN      = 13'd1920;
    localparam logic [HUE_W-1:0] SIXTH_TURN      = 13'd960;
    localparam logic [HUE_W-1:0] HALF_TURN       = 13'd2880;
    localparam logic [HUE_W-1:0] TWO_THIRDS_TURN = 13'd3840;

    // Percent scale in 1/16 percent
    localparam logic [PCT_W-1:0] PCT_FULL = 11'd1600;
    localparam logic [PCT_W-1:0] PCT_HALF = 11'd800;

    // Curve weight, 0..960
    localparam int WT_W = 10;

    // p and q in units of 1/2560000; products of l and s
    localparam int PQ_W = 22;
    localparam int LS_W = 22;
    localparam int WIDE_W = 23;
    localparam logic [PQ_W-1:0] PQ_SCALE = 22'd2560000;

    // Channel value in units of 1/(2560000*960) and its rounding
    localparam int DEN_W = 32;
    localparam logic [DEN_W-1:0] DEN      = 32'd2457600000;
    localparam logic [DEN_W-1:0] HALF_DEN = 32'd1228800000;
    localparam int NUM_W = DEN_W + LEVEL_BITS;

    // The divisor is 9375 * 2^18: drop the power of two first, then
    // divide by the odd part through a rounded-up reciprocal. The shift of
    // LEVEL_BITS + 27 keeps the quotient exact over the whole dividend range.
    localparam int DEN_SHIFT = 18;
    localparam int DEN_ODD_W = 14;
    localparam logic [DEN_ODD_W-1:0] DEN_ODD = 14'd9375;
    localparam int QX_W        = NUM_W - DEN_SHIFT;
    localparam int RECIP_SHIFT = LEVEL_BITS + 27;
    localparam int RECIP_W     = LEVEL_BITS + 14;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(DEN_ODD) - 64'd1) / 64'(DEN_ODD));
    localparam int PROD_W = QX_W + RECIP_W;

    // Register stages ahead of the divider
    localparam int FRONT_STAGES = 7;

    // Channel order on the output
    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;

    // Dividend per channel with the power of two already dropped
    typedef logic [NUM_CH-1:0][QX_W-1:0] div_lanes_t;

    // Output level per channel
    typedef logic [NUM_CH-1:0][LEVEL_BITS-1:0] level_lanes_t;

    // Piecewise-linear hue curve: rise, hold at q, fall, hold at p
    function automatic logic [WT_W-1:0] hue_weight(input logic [HUE_W-1:0] t);
        logic [HUE_W-1:0] fall;
        fall = TWO_THIRDS_TURN - t;
        if (t < SIXTH_TURN)
            hue_weight = t[WT_W-1:0];
        else if (t < HALF_TURN)
            hue_weight = SIXTH_TURN[WT_W-1:0];
        else if (t < TWO_THIRDS_TURN)
            hue_weight = fall[WT_W-1:0];
        else
            hue_weight = '0;
    endfunction

endpackage

[sv/hsl2rgb_div_step.sv]
module hsl2rgb_div_step
    import hsl2rgb_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         en,
    input  logic         in_vld,
    input  div_lanes_t   in_data,
    output logic         out_vld,
    output level_lanes_t out_data
);

    logic         vld_reg;
    level_lanes_t data_reg;
    level_lanes_t data_next;

    // Divide each channel by the odd part of the divisor: multiply by the
    // rounded-up reciprocal and drop the fraction bits
    always_comb
    begin
        logic [PROD_W-1:0] prod;
        for (int c = 0; c < NUM_CH; c++)
        begin
            prod         = PROD_W'(in_data[c]) * PROD_W'(RECIP);
            data_next[c] = prod[RECIP_SHIFT +: LEVEL_BITS];
        end
    end

    // Advance valid with the pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (en)
            vld_reg <= in_vld;
    end

    // Hold data when stalled
    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign out_vld  = vld_reg;
    assign out_data = data_reg;

endmodule

[sv/hsl_to_rgb_converter_top.sv]
// HSL to RGB colour converter.
// Input stream: one item per colour, tdata carries hue in 1/16 degree,
// saturation and lightness in 1/16 percent. Out-of-range hue wraps once,
// saturation and lightness above 100 percent clamp to 100 percent.
// Output stream: one item per input item, in order, carrying red, green and
// blue levels where all ones means full scale, rounded half up.
// Pipeline: eight register stages: seven arithmetic stages, then one
// stage that divides by the scale constant through a reciprocal multiply.
// Throughput: one item per cycle while the output is not stalled; the pipeline is fully registered.
// Stalls: when the output item is offered and not taken, the whole pipeline
// holds and s_axis_tready drops; while the output is empty the pipeline
// keeps moving, so bubbles drain and new items are taken.
// Reset: all valid bits clear; no item is held after reset and the block
// is ready as soon as rst_n rises.
`include "hsl_to_rgb_converter_top_defines.svh"

module hsl_to_rgb_converter_top
    import hsl2rgb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    // [12:0] hue_sixteenth_deg, [23:13] sat_sixteenth_pct,
    // [34:24] light_sixteenth_pct, rest zero
    input  logic [IN_TDW-1:0]  s_axis_tdata,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // [15:0] red_level, [31:16] green_level, [47:32] blue_level (at 16-bit
    // levels; each LEVEL_BITS wide in that order), rest zero
    output logic [OUT_TDW-1:0] m_axis_tdata
);

    logic                          en;
    logic [FRONT_STAGES-1:0]       front_vld_reg;

    logic [HUE_W-1:0]              h1_reg;
    logic [PCT_W-1:0]              s1_reg;
    logic [PCT_W-1:0]              l1_reg;

    logic [LS_W-1:0]               ls2_reg;
    logic [PCT_W-1:0]              l2_reg;
    logic [PCT_W-1:0]              s2_reg;
    logic [NUM_CH-1:0][HUE_W-1:0]  t2_reg;
    logic [NUM_CH-1:0][HUE_W-1:0]  t2_next;

    logic [PQ_W-1:0]               q3_reg;
    logic [PCT_W-1:0]              l3_reg;
    logic [NUM_CH-1:0][WT_W-1:0]   w3_reg;

    logic [PQ_W-1:0]               p4_reg;
    logic [PQ_W-1:0]               d4_reg;
    logic [NUM_CH-1:0][WT_W-1:0]   w4_reg;

    logic [DEN_W-1:0]              pm5_reg;
    logic [NUM_CH-1:0][DEN_W-1:0]  dw5_reg;

    logic [NUM_CH-1:0][DEN_W-1:0]  v6_reg;

    div_lanes_t                    x7_reg;
    div_lanes_t                    x7_next;

    logic                          div_vld;
    level_lanes_t                  div_lvl;

    logic [HUE_W-1:0]              h_in;
    logic [PCT_W-1:0]              s_in;
    logic [PCT_W-1:0]              l_in;
    logic [HUE_W-1:0]              tr_sum;
    logic [WIDE_W-1:0]             l1600;
    logic [WIDE_W-1:0]             q_wide;
    logic [WIDE_W-1:0]             l3200;
    logic [WIDE_W-1:0]             p_wide;
    logic [WIDE_W-1:0]             d_wide;

    // Global advance: move unless the output item is waiting
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    assign h_in = s_axis_tdata[HUE_W-1:0];
    assign s_in = s_axis_tdata[HUE_W+PCT_W-1:HUE_W];
    assign l_in = s_axis_tdata[HUE_W+2*PCT_W-1:HUE_W+PCT_W];

    // Advance the valid bits of the front stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            front_vld_reg <= '0;
        else if (en)
            front_vld_reg <= {front_vld_reg[FRONT_STAGES-2:0], s_axis_tvalid};
    end

    // Stage 2 hue offsets, each wrapped once; red may stay at exactly one turn
    always_comb
    begin
        tr_sum = h1_reg + THIRD_TURN;
        t2_next[CH_GREEN] = h1_reg;
        t2_next[CH_RED]   = (tr_sum > FULL_TURN) ? tr_sum - FULL_TURN : tr_sum;
        t2_next[CH_BLUE]  = (h1_reg < THIRD_TURN) ? h1_reg + TWO_THIRDS_TURN
                                                  : h1_reg - THIRD_TURN;
    end

    // Stage 3 q from lightness and saturation
    always_comb
    begin
        l1600 = WIDE_W'(l2_reg) * WIDE_W'(PCT_FULL);
        if (l2_reg < PCT_HALF)
            q_wide = l1600 + WIDE_W'(ls2_reg);
        else
            q_wide = l1600 + WIDE_W'(s2_reg) * WIDE_W'(PCT_FULL) - WIDE_W'(ls2_reg);
    end

    // Stage 4 p = 2L - q and the span q - p = 2q - 2L
    always_comb
    begin
        l3200  = WIDE_W'(l3_reg) * WIDE_W'(2 * PCT_FULL);
        p_wide = l3200 - WIDE_W'(q3_reg);
        d_wide = {q3_reg, 1'b0} - l3200;
    end

    // Stage 7 rounded dividend v*(2^LEVEL_BITS - 1) + den/2; drop the power
    // of two in the divisor here
    always_comb
    begin
        logic [NUM_W-1:0] num;
        for (int c = 0; c < NUM_CH; c++)
        begin
            num = (NUM_W'(v6_reg[c]) << LEVEL_BITS) - NUM_W'(v6_reg[c])
                  + NUM_W'(HALF_DEN);
            x7_next[c] = num[NUM_W-1:DEN_SHIFT];
        end
    end

    // Front arithmetic stages; data holds on a stall
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // Stage 1: wrap hue, clamp saturation and lightness
            h1_reg <= (h_in >= FULL_TURN) ? h_in - FULL_TURN : h_in;
            s1_reg <= (s_in > PCT_FULL) ? PCT_FULL : s_in;
            l1_reg <= (l_in > PCT_FULL) ? PCT_FULL : l_in;
            // Stage 2: product of lightness and saturation, channel hues
            ls2_reg <= LS_W'(l1_reg) * LS_W'(s1_reg);
            l2_reg  <= l1_reg;
            s2_reg  <= s1_reg;
            t2_reg  <= t2_next;
            // Stage 3: q and curve weights
            q3_reg <= q_wide[PQ_W-1:0];
            l3_reg <= l2_reg;
            for (int c = 0; c < NUM_CH; c++)
                w3_reg[c] <= hue_weight(t2_reg[c]);
            // Stage 4: p and span
            p4_reg <= p_wide[PQ_W-1:0];
            d4_reg <= d_wide[PQ_W-1:0];
            w4_reg <= w3_reg;
            // Stage 5: scale p by a sixth turn, span by weight
            pm5_reg <= DEN_W'(p4_reg) * DEN_W'(SIXTH_TURN);
            for (int c = 0; c < NUM_CH; c++)
                dw5_reg[c] <= DEN_W'(d4_reg) * DEN_W'(w4_reg[c]);
            // Stage 6: channel values
            for (int c = 0; c < NUM_CH; c++)
                v6_reg[c] <= pm5_reg + dw5_reg[c];
            // Stage 7: divider load
            x7_reg <= x7_next;
        end
    end

    // Divide stage, which is also the output register. The dividend stays
    // below den * 2^LEVEL_BITS, so the quotient never exceeds full scale.
    hsl2rgb_div_step u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (front_vld_reg[FRONT_STAGES-1]),
        .in_data  (x7_reg),
        .out_vld  (div_vld),
        .out_data (div_lvl)
    );

    assign m_axis_tvalid = div_vld;
    always_comb
    begin
        m_axis_tdata = '0;
        for (int c = 0; c < NUM_CH; c++)
            m_axis_tdata[c*LEVEL_BITS +: LEVEL_BITS] = div_lvl[c];
    end

    // Hue lies inside the turn after the first stage
    `HSL_ASSERT_NOW(a_hue_wrapped, clk, rst_n, front_vld_reg[0], h1_reg < FULL_TURN)
    // q never exceeds full scale
    `HSL_ASSERT_NOW(a_q_range, clk, rst_n, front_vld_reg[2], q3_reg <= PQ_SCALE)
    // Curve weights stay within a sixth of a turn
    `HSL_ASSERT_NOW(a_weight_range, clk, rst_n, front_vld_reg[2],
        (w3_reg[CH_RED] <= SIXTH_TURN[WT_W-1:0]) && (w3_reg[CH_GREEN] <= SIXTH_TURN[WT_W-1:0])
        && (w3_reg[CH_BLUE] <= SIXTH_TURN[WT_W-1:0]))
    // Channel values never exceed the divisor
    `HSL_ASSERT_NOW(a_value_range, clk, rst_n, front_vld_reg[5],
        (v6_reg[CH_RED] <= DEN) && (v6_reg[CH_GREEN] <= DEN) && (v6_reg[CH_BLUE] <= DEN))
    // A stall freezes every valid bit in the pipeline
    `HSL_ASSERT_NEXT(a_stall_holds, clk, rst_n, !en,
        $stable(front_vld_reg) && $stable(div_vld))

endmodule

[sim/hsl_to_rgb_converter_top_tb.sv]
module hsl_to_rgb_converter_top_tb
    import hsl2rgb_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [PCT_W-1:0] light;
        logic [PCT_W-1:0] sat;
        logic [HUE_W-1:0] hue;
    } hsl_item_t;

    typedef struct packed {
        logic [LEVEL_BITS-1:0] blue;
        logic [LEVEL_BITS-1:0] green;
        logic [LEVEL_BITS-1:0] red;
    } rgb_levels_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [IN_TDW-1:0]  s_axis_tdata = '0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [OUT_TDW-1:0] m_axis_tdata;

    hsl_item_t   hsl_backlog[$];
    rgb_levels_t awaited_rgb[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int colours_taken  = 0;
    int colours_checked = 0;
    int directed_count = 0;
    int mismatches     = 0;

    hsl_to_rgb_converter_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Level of one channel: sample the hue curve between p and q, scale, round half up
    function automatic logic [LEVEL_BITS-1:0] curve_level(longint unsigned p_sc,
                                                          longint unsigned q_sc, int pos);
        longint unsigned wgt;
        longint unsigned val;
        longint unsigned lvl;
        longint unsigned top;
        longint unsigned den;
        top = (64'd1 << LEVEL_BITS) - 1;
        den = longint'(PQ_SCALE) * longint'(SIXTH_TURN);
        // wrap once; a position of exactly one turn stays and falls on p
        if (pos < 0)
            pos += int'(FULL_TURN);
        if (pos > int'(FULL_TURN))
            pos -= int'(FULL_TURN);
        if (pos < int'(SIXTH_TURN))
            wgt = pos;
        else if (pos < int'(HALF_TURN))
            wgt = SIXTH_TURN;
        else if (pos < int'(TWO_THIRDS_TURN))
            wgt = int'(TWO_THIRDS_TURN) - pos;
        else
            wgt = 0;
        val = p_sc * SIXTH_TURN + (q_sc - p_sc) * wgt;
        lvl = (val * top + den / 2) / den;
        if (lvl > top)
            lvl = top;
        return lvl[LEVEL_BITS-1:0];
    endfunction

    // Expected RGB levels for one HSL colour
    function automatic rgb_levels_t predict_rgb(hsl_item_t c);
        longint unsigned hue;
        longint unsigned sat;
        longint unsigned lit;
        longint unsigned q_sc;
        longint unsigned p_sc;
        rgb_levels_t     res;
        hue = c.hue;
        if (hue >= FULL_TURN)
            hue -= FULL_TURN;
        sat = (c.sat > PCT_FULL) ? PCT_FULL : c.sat;
        lit = (c.light > PCT_FULL) ? PCT_FULL : c.light;
        if (lit < PCT_HALF)
            q_sc = lit * (PCT_FULL + sat);
        else
            q_sc = PCT_FULL * (lit + sat) - lit * sat;
        p_sc = 2 * PCT_FULL * lit - q_sc;
        res.red   = curve_level(p_sc, q_sc, int'(hue) + int'(THIRD_TURN));
        res.green = curve_level(p_sc, q_sc, int'(hue));
        res.blue  = curve_level(p_sc, q_sc, int'(hue) - int'(THIRD_TURN));
        return res;
    endfunction

    // Random colour, weighted towards curve corners, gray, the lightness split and the limits
    function automatic hsl_item_t random_colour();
        int        marks[7] = '{0, 960, 1920, 2880, 3840, 4800, 5759};
        hsl_item_t c;
        c.hue   = 13'($urandom_range(5759));
        c.sat   = 11'($urandom_range(1600));
        c.light = 11'($urandom_range(1600));
        case ($urandom_range(9))
            0:
            begin
                c.hue   = 13'($urandom);
                c.sat   = 11'($urandom);
                c.light = 11'($urandom);
            end
            1, 2:
                c.hue = 13'(marks[$urandom_range(6)] + int'($urandom_range(6)) - 3);
            3:
                c.sat = ($urandom_range(1) == 0) ? 11'd0 : PCT_FULL;
            4:
            begin
                case ($urandom_range(3))
                    0: c.light = PCT_HALF;
                    1: c.light = PCT_HALF - 11'd1;
                    2: c.light = 11'd0;
                    default: c.light = PCT_FULL;
                endcase
            end
            default:
            begin
            end
        endcase
        return c;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    // Drive input items from the backlog; hold an item until it is taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                awaited_rgb.push_back(predict_rgb(hsl_backlog.pop_front()));
                colours_taken++;
            end
            if (!(s_axis_tvalid && !s_axis_tready))
            begin
                if (hsl_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= IN_TDW'(hsl_backlog[0]);
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Check each output item against the oldest prediction and stall at random
    always @(posedge clk or negedge rst_n)
    begin
        rgb_levels_t got;
        rgb_levels_t want;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.red   = m_axis_tdata[CH_RED * LEVEL_BITS +: LEVEL_BITS];
                got.green = m_axis_tdata[CH_GREEN * LEVEL_BITS +: LEVEL_BITS];
                got.blue  = m_axis_tdata[CH_BLUE * LEVEL_BITS +: LEVEL_BITS];
                if (awaited_rgb.size() == 0)
                begin
                    report_mismatch($sformatf("output item with no colour awaited (%h)",
                                              m_axis_tdata));
                end
                else
                begin
                    want = awaited_rgb.pop_front();
                    if (got.red !== want.red)
                        report_mismatch($sformatf("item %0d red %h, predicted %h",
                                                  colours_checked, got.red, want.red));
                    if (got.green !== want.green)
                        report_mismatch($sformatf("item %0d green %h, predicted %h",
                                                  colours_checked, got.green, want.green));
                    if (got.blue !== want.blue)
                        report_mismatch($sformatf("item %0d blue %h, predicted %h",
                                                  colours_checked, got.blue, want.blue));
                end
                colours_checked++;
            end
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Queue one flow-control phase and wait for it to drain
    task automatic run_phase(input int n_colours, input int idle_pct, input int stall_pct);
        @(negedge clk);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < n_colours; i++)
            hsl_backlog.push_back(random_colour());
        while (hsl_backlog.size() != 0 || s_axis_tvalid || awaited_rgb.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        hsl_item_t directed[$];
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // corners of the fields, gray, the lightness split, curve corners and wraps
        directed.push_back('{light: 11'd0,    sat: 11'd0,    hue: 13'd0});
        directed.push_back('{light: PCT_FULL, sat: PCT_FULL, hue: 13'd5759});
        directed.push_back('{light: 11'd800,  sat: 11'd0,    hue: 13'd1234});
        directed.push_back('{light: 11'd800,  sat: PCT_FULL, hue: 13'd0});
        directed.push_back('{light: 11'd799,  sat: PCT_FULL, hue: 13'd1920});
        directed.push_back('{light: 11'd800,  sat: PCT_FULL, hue: 13'd3840});
        directed.push_back('{light: 11'd600,  sat: 11'd1000, hue: 13'd959});
        directed.push_back('{light: 11'd600,  sat: 11'd1000, hue: 13'd960});
        directed.push_back('{light: 11'd1000, sat: 11'd700,  hue: 13'd2879});
        directed.push_back('{light: 11'd1000, sat: 11'd700,  hue: 13'd2880});
        directed.push_back('{light: 11'd1000, sat: 11'd700,  hue: 13'd3839});
        directed.push_back('{light: 11'd1200, sat: 11'd1599, hue: 13'd4800});
        directed.push_back('{light: 11'd400,  sat: 11'd1,    hue: 13'd1919});
        directed.push_back('{light: 11'd700,  sat: 11'd1500, hue: 13'd5760});
        directed.push_back('{light: 11'd700,  sat: 11'd1500, hue: 13'd8191});
        directed.push_back('{light: 11'd1,    sat: 11'd2047, hue: 13'd300});
        directed.push_back('{light: 11'd2047, sat: 11'd500,  hue: 13'd2000});
        directed.push_back('{light: 11'd2047, sat: 11'd2047, hue: 13'd7680});
        directed.push_back('{light: 11'd1601, sat: 11'd1601, hue: 13'd4095});
        directed.push_back('{light: 11'd1599, sat: 11'd800,  hue: 13'd4096});
        directed_count = directed.size();
        @(negedge clk);
        foreach (directed[i])
            hsl_backlog.push_back(directed[i]);

        run_phase(120, 0, 0);
        run_phase(110, 86, 0);
        run_phase(110, 0, 86);
        run_phase(110, 32, 32);

        // let any stray output item show up
        repeat (LEVEL_BITS + 30) @(posedge clk);

        $display("Converted %0d colours (%0d directed) through four flow-control phases,",
                 colours_checked, directed_count);
        $display("including hue wrap, clamped saturation and lightness, and gray inputs.");
        if (mismatches == 0 && colours_checked == colours_taken)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #4_000_000;
        $display("Timed out with %0d colours still awaited.", awaited_rgb.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

[hsl_to_rgb_converter_top.f]
+incdir+sv
sv/hsl2rgb_pkg.sv
sv/hsl2rgb_div_step.sv
sv/hsl_to_rgb_converter_top.sv
sim/hsl_to_rgb_converter_top_tb.sv
